// ===== rtl/core/ptt_pkg.sv =====
// ============================================================================
// ptt_pkg : periodic task timer bank shared definitions
// Sizes, codes, state encoding and the structs passed between the sequencer,
// the task table and the top level.
// ============================================================================
package ptt_pkg;

   localparam int TASKS       = 8;
   localparam int MAX_RESULTS = 8;

   localparam int MODE_W   = 3;
   localparam int ID_W     = 4;
   localparam int TICK_W   = 32;
   localparam int STATUS_W = 2;

   localparam int IDX_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W     = $clog2(TASKS + 1);
   localparam int DUE_CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W     = (CNT_W > ID_W) ? CNT_W : ID_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_PASS    = 3'd1,
      MODE_CLEAR   = 3'd2,
      MODE_CREATE  = 3'd3,
      MODE_START   = 3'd4,
      MODE_STOP    = 3'd5,
      MODE_SET_IVL = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BAD_ID = 2'd2
   } status_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_DUE    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              create;
      logic              start;
      logic              stop;
      logic              set_ivl;
      logic              restamp;
      logic [IDX_W-1:0]  widx;
      logic [IDX_W-1:0]  ridx;
      logic [TICK_W-1:0] ivl;
   } tbl_cmd_type;

   typedef struct packed {
      logic [0:0]          kind;
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     task_number;
      logic [TICK_W-1:0]   tick_now;
      logic                last_of_run;
   } rsp_type;

endpackage

// ===== rtl/core/ptt_ifs.sv =====
// ============================================================================
// ptt_ifs : request and response channels
// Valid/ready channels carrying one command item and one result item.
// ============================================================================
interface ptt_req_if;
   logic                       valid;
   logic                       ready;
   logic [ptt_pkg::MODE_W-1:0] mode;
   logic [ptt_pkg::ID_W-1:0]   task_id;
   logic [ptt_pkg::TICK_W-1:0] interval;

   modport source (output valid, output mode, output task_id, output interval,
                   input ready);
   modport sink   (input valid, input mode, input task_id, input interval,
                   output ready);
endinterface

interface ptt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ptt_pkg::STATUS_W-1:0] status;
   logic [ptt_pkg::ID_W-1:0]     task_number;
   logic [ptt_pkg::TICK_W-1:0]   tick_now;
   logic                         last_of_run;

   modport source (output valid, output kind, output status, output task_number,
                   output tick_now, output last_of_run, input ready);
   modport sink   (input valid, input kind, input status, input task_number,
                   input tick_now, input last_of_run, output ready);
endinterface

// ===== rtl/core/periodic_task_timer_bank.sv =====
// ============================================================================
// periodic_task_timer_bank : bank of periodic task timers
// Command-stepped wrapping tick, a small task table and a sequencer that runs
// commands and scheduler passes, reporting status and due-task results.
// ============================================================================
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    mode, task_id, interval
//   rsp_bus   out  valid/ready    kind, status, task_number, tick_now, last_of_run
//
// Tick and unknown mode: latched in idle, executed in the exec state. Other
// commands: the same, plus any wait in exec for the response register to drain.
// Pass: exec, then one scan step per task in use (one due check each in the shared
// compare unit), then one due result per cycle while rsp_bus is ready.
// Sync reset clears tick, task count and run flags; no clearing pass.
// A response waits in its register while the next request is taken.
module periodic_task_timer_bank (
   input  logic      clock,
   input  logic      reset,
   ptt_req_if.sink   req_bus,
   ptt_rsp_if.source rsp_bus
);

   logic [ptt_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic                       tick_inc;
   logic                       tbl_due;
   ptt_pkg::tbl_cmd_type       tbl_cmd;

   assign tick_in = tick_inc ? tick_ff + ptt_pkg::TICK_W'(1) : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

   ptt_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .tick  (tick_ff),
      .due   (tbl_due)
   );

   ptt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .tick     (tick_ff),
      .tbl_due  (tbl_due),
      .tbl_cmd  (tbl_cmd),
      .tick_inc (tick_inc)
   );

endmodule

// ===== rtl/core/ptt_table.sv =====
// ============================================================================
// ptt_table : task table and due check
// Per-task period, last-run stamp and run flag, with the shared subtract and
// compare unit that tests one task per cycle.
// ============================================================================
module ptt_table (
   input  logic                        clock,
   input  logic                        reset,
   input  ptt_pkg::tbl_cmd_type        cmd,
   input  logic [ptt_pkg::TICK_W-1:0]  tick,
   output logic                        due
);

   logic [ptt_pkg::TICK_W-1:0] period_ff [ptt_pkg::TASKS];
   logic [ptt_pkg::TICK_W-1:0] last_ff   [ptt_pkg::TASKS];
   logic [ptt_pkg::TASKS-1:0]  run_ff;
   logic [ptt_pkg::TASKS-1:0]  run_in;
   logic [ptt_pkg::TICK_W-1:0] elapsed;

   always_comb begin
      run_in = run_ff;
      if (cmd.clear) begin
         run_in = '0;
      end else if (cmd.create || cmd.stop) begin
         run_in[cmd.widx] = 1'b0;
      end else if (cmd.start) begin
         run_in[cmd.widx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.create || cmd.set_ivl) begin
         period_ff[cmd.widx] <= cmd.ivl;
      end
      if (cmd.create) begin
         last_ff[cmd.widx] <= '0;
      end else if (cmd.start || cmd.restamp) begin
         last_ff[cmd.widx] <= tick;
      end
   end

   // elapsed time wraps modulo 2^32
   assign elapsed = tick - last_ff[cmd.ridx];
   assign due     = run_ff[cmd.ridx] && (elapsed >= period_ff[cmd.ridx]);

endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// ============================================================================
// ptt_ctrl : command sequencer
// Latches one request, runs commands and the task scan against the table,
// and loads results into the response register.
// ============================================================================
module ptt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   ptt_req_if.sink                     req_bus,
   ptt_rsp_if.source                   rsp_bus,
   input  logic [ptt_pkg::TICK_W-1:0]  tick,
   input  logic                        tbl_due,
   output ptt_pkg::tbl_cmd_type        tbl_cmd,
   output logic                        tick_inc
);

   ptt_pkg::state_type                 state_ff, state_in;
   logic [ptt_pkg::MODE_W-1:0]         mode_ff;
   logic [ptt_pkg::ID_W-1:0]           id_ff;
   logic [ptt_pkg::TICK_W-1:0]         ivl_ff;
   logic [ptt_pkg::CNT_W-1:0]          tasks_ff, tasks_in;
   logic [ptt_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [ptt_pkg::TASKS-1:0]          mask_ff, mask_in;
   logic [ptt_pkg::DUE_CNT_W-1:0]      cnt_ff, cnt_in;
   ptt_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                               rsp_valid_ff;
   logic                               rsp_load;

   logic                               req_fire;
   logic                               out_free;
   logic                               id_ok;
   logic                               full;
   logic                               scan_end;
   logic                               due_hit;
   logic [ptt_pkg::TASKS-1:0]          mask_next;
   logic [ptt_pkg::TASKS-1:0]          low_bit;
   logic [ptt_pkg::TASKS-1:0]          rest;
   logic [ptt_pkg::IDX_W-1:0]          emit_idx;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign id_ok    = ptt_pkg::CMP_W'(id_ff) < ptt_pkg::CMP_W'(tasks_ff);
   assign full     = tasks_ff == ptt_pkg::CNT_W'(ptt_pkg::TASKS);
   assign scan_end = (ptt_pkg::CNT_W'(idx_ff) + ptt_pkg::CNT_W'(1)) == tasks_ff;
   assign due_hit  = tbl_due && (cnt_ff != ptt_pkg::DUE_CNT_W'(ptt_pkg::MAX_RESULTS));
   assign mask_next = due_hit ? (mask_ff | (ptt_pkg::TASKS'(1) << idx_ff)) : mask_ff;
   assign low_bit  = mask_ff & (~mask_ff + ptt_pkg::TASKS'(1));
   assign rest     = mask_ff & ~low_bit;

   always_comb begin
      emit_idx = '0;
      for (int j = 0; j < ptt_pkg::TASKS; j++) begin
         if (low_bit[j]) begin
            emit_idx = emit_idx | ptt_pkg::IDX_W'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ptt_pkg::ST_EXEC;
            end
         end
         ptt_pkg::ST_EXEC: begin
            unique case (mode_ff)
               ptt_pkg::MODE_TICK: state_in = ptt_pkg::ST_IDLE;
               ptt_pkg::MODE_PASS: begin
                  state_in = (tasks_ff == '0) ? ptt_pkg::ST_IDLE : ptt_pkg::ST_SCAN;
               end
               ptt_pkg::MODE_CLEAR, ptt_pkg::MODE_CREATE, ptt_pkg::MODE_START,
               ptt_pkg::MODE_STOP, ptt_pkg::MODE_SET_IVL: begin
                  if (out_free) begin
                     state_in = ptt_pkg::ST_IDLE;
                  end
               end
               default: state_in = ptt_pkg::ST_IDLE;
            endcase
         end
         ptt_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = (mask_next != '0) ? ptt_pkg::ST_EMIT : ptt_pkg::ST_IDLE;
            end
         end
         ptt_pkg::ST_EMIT: begin
            if (out_free && rest == '0) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      tbl_cmd      = '0;
      tbl_cmd.ridx = idx_ff;
      tbl_cmd.ivl  = ivl_ff;
      tick_inc     = 1'b0;
      tasks_in     = tasks_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rsp_load     = 1'b0;
      rsp_in.kind        = ptt_pkg::KIND_STATUS;
      rsp_in.status      = ptt_pkg::STATUS_OK;
      rsp_in.task_number = '0;
      rsp_in.tick_now    = tick;
      rsp_in.last_of_run = 1'b1;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in  = '0;
               mask_in = '0;
               cnt_in  = '0;
            end
         end
         ptt_pkg::ST_EXEC: begin
            unique case (mode_ff)
               ptt_pkg::MODE_TICK: tick_inc = 1'b1;
               ptt_pkg::MODE_CLEAR: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     tbl_cmd.clear = 1'b1;
                     tasks_in      = '0;
                  end
               end
               ptt_pkg::MODE_CREATE: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_in.status = ptt_pkg::STATUS_FULL;
                     end else begin
                        tbl_cmd.create     = 1'b1;
                        tbl_cmd.widx       = tasks_ff[ptt_pkg::IDX_W-1:0];
                        tasks_in           = tasks_ff + ptt_pkg::CNT_W'(1);
                        rsp_in.task_number = ptt_pkg::ID_W'(tasks_ff);
                     end
                  end
               end
               ptt_pkg::MODE_START, ptt_pkg::MODE_STOP, ptt_pkg::MODE_SET_IVL: begin
                  if (out_free) begin
                     rsp_load           = 1'b1;
                     rsp_in.task_number = id_ff;
                     if (!id_ok) begin
                        rsp_in.status = ptt_pkg::STATUS_BAD_ID;
                     end else begin
                        tbl_cmd.widx    = id_ff[ptt_pkg::IDX_W-1:0];
                        tbl_cmd.start   = mode_ff == ptt_pkg::MODE_START;
                        tbl_cmd.stop    = mode_ff == ptt_pkg::MODE_STOP;
                        tbl_cmd.set_ivl = mode_ff == ptt_pkg::MODE_SET_IVL;
                     end
                  end
               end
               default: ;
            endcase
         end
         ptt_pkg::ST_SCAN: begin
            tbl_cmd.restamp = due_hit;
            tbl_cmd.widx    = idx_ff;
            mask_in         = mask_next;
            cnt_in          = cnt_ff + ptt_pkg::DUE_CNT_W'(due_hit);
            idx_in          = idx_ff + ptt_pkg::IDX_W'(1);
         end
         ptt_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_in.kind        = ptt_pkg::KIND_DUE;
               rsp_in.task_number = ptt_pkg::ID_W'(emit_idx);
               rsp_in.last_of_run = rest == '0;
               mask_in            = rest;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptt_pkg::ST_IDLE;
         tasks_ff     <= '0;
         idx_ff       <= '0;
         mask_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tasks_ff <= tasks_in;
         idx_ff   <= idx_in;
         mask_ff  <= mask_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_bus.mode;
         id_ff   <= req_bus.task_id;
         ivl_ff  <= req_bus.interval;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_bus.ready       = state_ff == ptt_pkg::ST_IDLE;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_ff.kind;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.task_number = rsp_ff.task_number;
   assign rsp_bus.tick_now    = rsp_ff.tick_now;
   assign rsp_bus.last_of_run = rsp_ff.last_of_run;

   a_tasks_bound: assert property (@(posedge clock) disable iff (reset)
      ptt_pkg::CMP_W'(tasks_ff) <= ptt_pkg::CMP_W'(ptt_pkg::TASKS))
      else $error("task count above table size");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptt_pkg::ST_EMIT |-> mask_ff != '0)
      else $error("emit with no due task pending");

   a_due_cap: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) <= ptt_pkg::MAX_RESULTS)
      else $error("due tasks above per-pass limit");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.kind == ptt_pkg::KIND_STATUS) |=> state_ff == ptt_pkg::ST_IDLE)
      else $error("sequencer busy after status result");

endmodule
